// ----- hw/rtl/pidaw_pkg.sv -----
// package: types, constants and saturation helpers for the pid anti-windup core
`timescale 1ns / 1ps
package pidaw_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegGainP = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAlpha = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutLo = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOutHi = 3'd5;
  localparam logic [CfgIdxW-1:0] RegIntLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegIntHi = 3'd7;

  localparam logic [AlphaW-1:0] AlphaOne = 17'd65536;

  typedef struct packed {
    logic               start;
    logic signed [32:0] dividend;
    logic        [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = 66'sh0_7FFF_FFFF;
      mn = -66'sh0_8000_0000;
      if (v > mx) sat66 = 32'sh7FFF_FFFF;
      else if (v < mn) sat66 = 32'sh8000_0000;
      else sat66 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
    logic signed [31:0] t;
    begin
      t = (v < lo) ? lo : v;
      clamp = (t > hi) ? hi : t;
    end
  endfunction

endpackage

// ----- hw/rtl/pidaw_div.sv -----
// serial restoring divider: signed 33-bit dividend scaled by 2^24 over unsigned 32-bit divisor, saturated
`timescale 1ns / 1ps
module pidaw_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidaw_pkg::div_req_t req_i,
  output pidaw_pkg::div_rsp_t rsp_o
);
  // dividend is diff * 2^24, |diff| < 2^33
  logic [57:0] rem_q, rem_d;
  logic [57:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] diff_abs;
  logic        fits;
  logic signed [59:0] sq;

  always_comb begin
    diff_abs = req_i.dividend[32] ? 33'(-req_i.dividend) : 33'(req_i.dividend);
    fits = 1'b0;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = {1'b0, diff_abs, 24'd0};
      dvs_d = req_i.divisor;
      neg_d = req_i.dividend[32];
      cnt_d = 6'd58;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = {rem_q[56:0], quo_q[57]};
      quo_d = {quo_q[56:0], 1'b0};
      fits = rem_d >= {26'd0, dvs_q};
      if (fits) begin
        rem_d = rem_d - {26'd0, dvs_q};
        quo_d[0] = 1'b1;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    sq = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    rsp_o.done = done_q;
    rsp_o.quot = pidaw_pkg::sat66(66'(sq));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end
endmodule

// ----- hw/rtl/pid_controller_antiwindup_core.sv -----
// top level: pid controller with conditional-integration anti-windup
`timescale 1ns / 1ps
// channel | direction | handshake
// in      | input     | in_valid_i / in_ready_o : target, measured, step_time
// out     | output    | out_valid_o / out_ready_i : drive, flags, integ_value
// cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i
// an accepted step's result is valid once the 58-step serial divider and six passes
// through the shared 33x33 multiplier are done; the first step after reset or a
// config write skips the divide; a rejected step sets out_valid_o straight from idle
// reset and any config write clear integrator, last error and filter state
// in_ready_o is low while an item is in work or its result waits on out_ready_i
module pid_controller_antiwindup_core #(
  parameter logic [31:0] DT_MIN = 32'd16777,
  parameter logic [31:0] DT_MAX = 32'd16777216
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  target_i,
  input  logic signed [31:0]  measured_i,
  input  logic        [31:0]  step_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  drive_o,
  output logic                rejected_o,
  output logic                sat_high_o,
  output logic                sat_low_o,
  output logic signed [31:0]  integ_value_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  localparam logic [3:0] SIdle = 4'd0, SMulP = 4'd1, SDiv = 4'd2, SWait = 4'd3,
                         SMulA = 4'd4, SMulB = 4'd5, SMulD = 4'd6, SMulE = 4'd7,
                         SMulI = 4'd8, SSum = 4'd9, SOut = 4'd10;

  logic signed [31:0] gp_q, gi_q, gd_q, olo_q, ohi_q, ilo_q, ihi_q;
  logic [16:0] alpha_q;
  logic signed [31:0] iacc_q, lerr_q, dfil_q;
  logic primed_q;
  logic [3:0] st_q, st_d;
  logic signed [31:0] err_q, dt_q, p_q, d_q, it_q, cand_q, raw_q;
  logic signed [65:0] acc_q;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [31:0] drv_q, ival_q;
  logic rej_q, hi_q, lo_q, ov_q;
  pidaw_pkg::div_req_t dreq;
  pidaw_pkg::div_rsp_t drsp;
  logic in_fire;
  logic signed [32:0] err33;
  logic signed [32:0] dd;
  logic signed [31:0] alpha_s, alpha_c;
  logic signed [31:0] rnd16, rnd24, cand_c;
  logic signed [33:0] sum34;
  logic signed [31:0] sum32;
  logic shi, slo;

  assign in_ready_o = (st_q == SIdle) && !ov_q;
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign drive_o = drv_q;
  assign rejected_o = rej_q;
  assign sat_high_o = hi_q;
  assign sat_low_o = lo_q;
  assign integ_value_o = ival_q;

  // error minus last error, taken while in SMulP
  assign dd = 33'(err_q) - 33'(lerr_q);

  pidaw_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    alpha_s = (alpha_q > pidaw_pkg::AlphaOne) ? 32'sd65536 : $signed({15'd0, alpha_q});
    alpha_c = 32'sd65536 - alpha_s;
    case (st_q)
      SMulP: begin ma = 33'(gp_q); mb = 33'(err_q); end
      SDiv: begin ma = 33'(err_q); mb = $signed({1'b0, dt_q}); end
      SMulA: begin ma = 33'(alpha_s); mb = 33'(raw_q); end
      SMulB: begin ma = 33'(alpha_c); mb = 33'(dfil_q); end
      SMulD: begin ma = 33'(gd_q); mb = 33'(dfil_q); end
      SMulI: begin ma = 33'(gi_q); mb = 33'(cand_q); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = 66'(ma * mb);
  end

  always_comb begin
    err33 = 33'(target_i) - 33'(measured_i);
    dreq.start = (st_q == SMulP) && primed_q;
    dreq.dividend = dd;
    dreq.divisor = dt_q;
    rnd16 = pidaw_pkg::sat66((prod + 66'sd32768) >>> 16);
    rnd24 = pidaw_pkg::sat66((prod + 66'sd8388608) >>> 24);
    cand_c = pidaw_pkg::clamp(pidaw_pkg::sat66(66'(iacc_q) + 66'(rnd24)), ilo_q, ihi_q);
    sum34 = 34'(p_q) + 34'(it_q) + 34'(d_q);
    sum32 = pidaw_pkg::sat66(66'(sum34));
    shi = sum32 > ohi_q;
    slo = sum32 < olo_q;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: if (in_fire && !(step_time_i < DT_MIN || step_time_i > DT_MAX ||
                               step_time_i == 32'd0)) st_d = SMulP;
      SMulP: st_d = SDiv;
      SDiv: st_d = primed_q ? SWait : SMulA;
      SWait: if (drsp.done) st_d = SMulA;
      SMulA: st_d = SMulB;
      SMulB: st_d = SMulD;
      SMulD: st_d = SMulI;
      SMulE: st_d = SMulI;
      SMulI: st_d = SSum;
      SSum: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      ov_q <= 1'b0;
      gp_q <= '0; gi_q <= '0; gd_q <= '0;
      alpha_q <= pidaw_pkg::AlphaOne;
      olo_q <= -32'sd65536; ohi_q <= 32'sd65536;
      ilo_q <= -32'sd65536; ihi_q <= 32'sd65536;
      iacc_q <= '0; lerr_q <= '0; dfil_q <= '0; primed_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pidaw_pkg::RegGainP: gp_q <= cfg_data_i;
          pidaw_pkg::RegGainI: gi_q <= cfg_data_i;
          pidaw_pkg::RegGainD: gd_q <= cfg_data_i;
          pidaw_pkg::RegAlpha: alpha_q <= cfg_data_i[16:0];
          pidaw_pkg::RegOutLo: olo_q <= cfg_data_i;
          pidaw_pkg::RegOutHi: ohi_q <= cfg_data_i;
          pidaw_pkg::RegIntLo: ilo_q <= cfg_data_i;
          pidaw_pkg::RegIntHi: ihi_q <= cfg_data_i;
          default: gp_q <= gp_q;
        endcase
        iacc_q <= '0; lerr_q <= '0; dfil_q <= '0; primed_q <= 1'b0;
      end else begin
        case (st_q)
          SIdle: if (in_fire && st_d == SIdle) ov_q <= 1'b1;
          SMulB: dfil_q <= pidaw_pkg::sat66((acc_q + prod + 66'sd32768) >>> 16);
          SSum: begin
            ov_q <= 1'b1;
            if ((!shi && !slo) || (shi && err_q < 0) || (slo && err_q > 0))
              iacc_q <= cand_q;
            lerr_q <= err_q;
            primed_q <= 1'b1;
          end
          default: ov_q <= ov_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      SIdle: if (in_fire) begin
        err_q <= pidaw_pkg::sat66(66'(err33));
        dt_q <= step_time_i;
        rej_q <= 1'b1; hi_q <= 1'b0; lo_q <= 1'b0;
        drv_q <= '0; ival_q <= iacc_q;
        raw_q <= '0;
      end
      SMulP: p_q <= rnd16;
      SDiv: cand_q <= cand_c;
      SWait: if (drsp.done) raw_q <= drsp.quot;
      SMulA: acc_q <= prod;
      SMulD: d_q <= rnd16;
      SMulI: it_q <= rnd16;
      SSum: begin
        rej_q <= 1'b0; hi_q <= shi; lo_q <= slo;
        drv_q <= pidaw_pkg::clamp(sum32, olo_q, ohi_q);
        ival_q <= ((!shi && !slo) || (shi && err_q < 0) || (slo && err_q > 0))
                  ? cand_q : iacc_q;
      end
      default: acc_q <= acc_q;
    endcase
  end
endmodule
